// ----- rtl/bra_pkg.sv -----
// bra_pkg: shared types and constants of the budget reservation admission block
// request and result payload structs, status and request type codes, widths
// no dependencies
package bra_pkg;

    localparam int TABLE_SLOTS_DEF = 16;

    localparam int ID_W    = 64;
    localparam int BYTES_W = 48;
    localparam int TOTAL_W = 52;
    // shared adder: 53-bit sums plus a sign bit for subtraction
    localparam int ALU_W   = 54;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 64;
    localparam logic [PADDR_W-1:0] ADDR_BUDGET = 3'd0;

    localparam logic [1:0] REQ_GATED   = 2'd0;
    localparam logic [1:0] REQ_UNCOND  = 2'd1;
    localparam logic [1:0] REQ_RELEASE = 2'd2;
    localparam logic [1:0] REQ_UNUSED  = 2'd3;

    localparam logic [2:0] ST_GRANT_NEW     = 3'd0;
    localparam logic [2:0] ST_GRANT_OLD     = 3'd1;
    localparam logic [2:0] ST_REFUSE_BUDGET = 3'd2;
    localparam logic [2:0] ST_REFUSE_FULL   = 3'd3;
    localparam logic [2:0] ST_RELEASED      = 3'd4;
    localparam logic [2:0] ST_NOT_FOUND     = 3'd5;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [ID_W-1:0]    request_id;
        logic [BYTES_W-1:0] est_bytes;
        logic [BYTES_W-1:0] external_bytes;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic [TOTAL_W-1:0] outstanding_bytes;
    } t_out_item;

endpackage

// ----- rtl/budget_reservation_admission.sv -----
// budget_reservation_admission: top level, request sequencer and reservation table
// depends on bra_pkg, bra_ram, bra_alu
//
//  channel   direction  handshake                      payload
//  request   in         i_in_valid / o_in_ready        i_in_item  (bra_pkg::t_in_item)
//  result    out        o_out_valid / i_out_ready      o_out_item (bra_pkg::t_out_item)
//  config    in         psel / penable / pwrite, APB   paddr, pwdata, prdata (64 bit)
//
// one request at a time: the table scan reads one slot per cycle from the slot RAM; the result
// follows the scan and, for a gated reserve with a nonzero budget, the budget check before it,
// and the next request can be taken in the cycle in which the result becomes valid
// a hit ends the scan early and a budget refusal skips it
// reset clears the valid bits, running sum and budget at once; no clearing pass
// a waiting result does not block the next request, only its completion

module budget_reservation_admission #(
    parameter int TABLE_SLOTS = bra_pkg::TABLE_SLOTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  bra_pkg::t_in_item            i_in_item,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output bra_pkg::t_out_item           o_out_item,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bra_pkg::PADDR_W-1:0]  paddr,
    input  logic [bra_pkg::PDATA_W-1:0]  pwdata,
    output logic [bra_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    localparam int IDXW   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNTW   = $clog2(TABLE_SLOTS + 1);
    localparam int WORD_W = bra_pkg::ID_W + bra_pkg::BYTES_W;
    localparam int ALU_W  = bra_pkg::ALU_W;
    localparam int BW     = bra_pkg::BYTES_W;
    localparam int TW     = bra_pkg::TOTAL_W;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_ADD1    = 7'b0000010,
        S_ADD2    = 7'b0000100,
        S_CMP     = 7'b0001000,
        S_SCAN    = 7'b0010000,
        S_RESOLVE = 7'b0100000,
        S_DONE    = 7'b1000000
    } t_state;

    t_state                r_state, n_state;
    logic [BW-1:0]         r_budget, n_budget;
    logic [TW-1:0]         r_total, n_total;
    logic [TABLE_SLOTS-1:0] r_valid, n_valid;
    logic                  r_out_valid, n_out_valid;

    logic                  r_is_release, n_is_release;
    logic [bra_pkg::ID_W-1:0] r_id, n_id;
    logic [BW-1:0]         r_est, n_est;
    logic [BW-1:0]         r_ext, n_ext;
    logic [ALU_W-1:0]      r_acc, n_acc;
    logic [CNTW-1:0]       r_idx, n_idx;
    logic                  r_cmp_pend, n_cmp_pend;
    logic                  r_cmp_vld, n_cmp_vld;
    logic [IDXW-1:0]       r_cmp_idx, n_cmp_idx;
    logic                  r_free_found, n_free_found;
    logic [IDXW-1:0]       r_free_idx, n_free_idx;
    logic                  r_hit, n_hit;
    logic [IDXW-1:0]       r_hit_idx, n_hit_idx;
    logic [BW-1:0]         r_hit_bytes, n_hit_bytes;
    logic [2:0]            r_status, n_status;
    bra_pkg::t_out_item    r_out, n_out;

    logic [ALU_W-1:0]      alu_a, alu_b, alu_res;
    logic                  alu_sub;
    logic                  ram_we;
    logic [WORD_W-1:0]     ram_rdata;
    logic [bra_pkg::ID_W-1:0] rd_id;
    logic [BW-1:0]         rd_bytes;
    logic [IDXW-1:0]       scan_addr;
    logic                  cfg_wr;
    logic                  in_fire;

    assign scan_addr = r_idx[IDXW-1:0];
    assign rd_id     = ram_rdata[WORD_W-1:BW];
    assign rd_bytes  = ram_rdata[BW-1:0];
    assign ram_we    = (r_state == S_RESOLVE) && !r_is_release && !r_hit && r_free_found;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;

    assign cfg_wr = psel && penable && pwrite && (paddr == bra_pkg::ADDR_BUDGET);
    assign pready = 1'b1;
    assign prdata = (paddr == bra_pkg::ADDR_BUDGET)
                    ? {{(bra_pkg::PDATA_W-BW){1'b0}}, r_budget} : '0;

    bra_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_free_idx),
        .i_wdata ({r_id, r_est}),
        .i_raddr (scan_addr),
        .o_rdata (ram_rdata)
    );

    bra_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_sub (alu_sub),
        .o_res (alu_res)
    );

    // operand selection for the shared adder
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (r_state)
            S_ADD1: begin
                alu_a = {{(ALU_W-BW){1'b0}}, r_ext};
                alu_b = {{(ALU_W-BW){1'b0}}, r_est};
            end
            S_ADD2: begin
                alu_a = r_acc;
                alu_b = {{(ALU_W-TW){1'b0}}, r_total};
            end
            S_CMP: begin
                alu_a   = {{(ALU_W-BW){1'b0}}, r_budget};
                alu_b   = r_acc;
                alu_sub = 1'b1;
            end
            S_RESOLVE: begin
                alu_a = {{(ALU_W-TW){1'b0}}, r_total};
                if (r_is_release) begin
                    alu_b   = {{(ALU_W-BW){1'b0}}, r_hit_bytes};
                    alu_sub = 1'b1;
                end else begin
                    alu_b = {{(ALU_W-BW){1'b0}}, r_est};
                end
            end
            default: begin
                alu_a = '0;
            end
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_budget     = cfg_wr ? pwdata[BW-1:0] : r_budget;
        n_total      = r_total;
        n_valid      = r_valid;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_is_release = r_is_release;
        n_id         = r_id;
        n_est        = r_est;
        n_ext        = r_ext;
        n_acc        = r_acc;
        n_idx        = r_idx;
        n_cmp_pend   = r_cmp_pend;
        n_cmp_vld    = r_cmp_vld;
        n_cmp_idx    = r_cmp_idx;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_hit        = r_hit;
        n_hit_idx    = r_hit_idx;
        n_hit_bytes  = r_hit_bytes;
        n_status     = r_status;
        n_out        = r_out;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_is_release = (i_in_item.req_type == bra_pkg::REQ_RELEASE) ||
                                   (i_in_item.req_type == bra_pkg::REQ_UNUSED);
                    n_id         = i_in_item.request_id;
                    n_est        = i_in_item.est_bytes;
                    n_ext        = i_in_item.external_bytes;
                    n_idx        = '0;
                    n_cmp_pend   = 1'b0;
                    n_free_found = 1'b0;
                    n_hit        = 1'b0;
                    if ((i_in_item.req_type == bra_pkg::REQ_GATED) && (r_budget != '0)) begin
                        n_state = S_ADD1;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_ADD1: begin
                n_acc   = alu_res;
                n_state = S_ADD2;
            end
            S_ADD2: begin
                n_acc   = alu_res;
                n_state = S_CMP;
            end
            S_CMP: begin
                // negative budget - demand means the demand exceeds the budget
                if (alu_res[ALU_W-1]) begin
                    n_status = bra_pkg::ST_REFUSE_BUDGET;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_cmp_pend && r_cmp_vld && (rd_id == r_id)) begin
                    n_hit       = 1'b1;
                    n_hit_idx   = r_cmp_idx;
                    n_hit_bytes = rd_bytes;
                    n_cmp_pend  = 1'b0;
                    n_state     = S_RESOLVE;
                end else if (r_idx == CNTW'(TABLE_SLOTS)) begin
                    n_cmp_pend = 1'b0;
                    n_state    = S_RESOLVE;
                end else begin
                    // slot read issued now, compared when the data returns
                    n_idx      = r_idx + CNTW'(1);
                    n_cmp_pend = 1'b1;
                    n_cmp_vld  = r_valid[scan_addr];
                    n_cmp_idx  = scan_addr;
                    if (!r_valid[scan_addr] && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_idx   = scan_addr;
                    end
                end
            end
            S_RESOLVE: begin
                n_state = S_DONE;
                if (r_is_release) begin
                    if (r_hit) begin
                        n_total            = alu_res[ALU_W-1] ? '0 : alu_res[TW-1:0];
                        n_valid[r_hit_idx] = 1'b0;
                        n_status           = bra_pkg::ST_RELEASED;
                    end else begin
                        n_status = bra_pkg::ST_NOT_FOUND;
                    end
                end else if (r_hit) begin
                    n_status = bra_pkg::ST_GRANT_OLD;
                end else if (!r_free_found) begin
                    n_status = bra_pkg::ST_REFUSE_FULL;
                end else begin
                    // saturate the running sum at its full width
                    n_total = (alu_res[ALU_W-1:TW] != '0) ? '1 : alu_res[TW-1:0];
                    n_valid[r_free_idx] = 1'b1;
                    n_status            = bra_pkg::ST_GRANT_NEW;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid             = 1'b1;
                    n_out.status            = r_status;
                    n_out.outstanding_bytes = r_total;
                    n_state                 = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_budget    <= '0;
            r_total     <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_budget    <= n_budget;
            r_total     <= n_total;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_release <= n_is_release;
        r_id         <= n_id;
        r_est        <= n_est;
        r_ext        <= n_ext;
        r_acc        <= n_acc;
        r_idx        <= n_idx;
        r_cmp_pend   <= n_cmp_pend;
        r_cmp_vld    <= n_cmp_vld;
        r_cmp_idx    <= n_cmp_idx;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_hit        <= n_hit;
        r_hit_idx    <= n_hit_idx;
        r_hit_bytes  <= n_hit_bytes;
        r_status     <= n_status;
        r_out        <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ----- rtl/bra_ram.sv -----
// bra_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module bra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/bra_alu.sv -----
// bra_alu: shared add / subtract unit of the admission sequencer
// depends on bra_pkg for the unit width
module bra_alu (
    input  logic [bra_pkg::ALU_W-1:0] i_a,
    input  logic [bra_pkg::ALU_W-1:0] i_b,
    input  logic                      i_sub,
    output logic [bra_pkg::ALU_W-1:0] o_res
);

    logic [bra_pkg::ALU_W-1:0] b_op;

    // subtract as a + ~b + 1, top bit is the sign for operands below 2^53
    assign b_op  = i_sub ? ~i_b : i_b;
    assign o_res = i_a + b_op + {{(bra_pkg::ALU_W-1){1'b0}}, i_sub};

endmodule
